// ===== rtl/compacting_id_table_defines.svh =====
// Assertion macros used by the compacting id table engine.
`ifndef COMPACTING_ID_TABLE_DEFINES_SVH
`define COMPACTING_ID_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CIT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cit assertion failed");

`else

`define CIT_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define CIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/cit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cit_pkg;

    localparam int CAPACITY    = 16;
    localparam int NAME_BITS   = 64;
    localparam int ID_W        = 32;
    localparam int TAG_W       = 64;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int COUNT_OUT_W = 5;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;

    localparam int S_TDATA_W   = ((TAG_W + ID_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = ID_W + TAG_W + COUNT_OUT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     waddr;
        logic [IDX_W-1:0]     raddr;
        logic [ID_W-1:0]      wid;
        logic [NAME_BITS-1:0] wname;
    } ram_cmd_t;

    typedef struct packed {
        status_t                status;
        logic [ID_W-1:0]        rid;
        logic [NAME_BITS-1:0]   rname;
        logic [COUNT_OUT_W-1:0] count;
    } result_t;

    function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[COUNT_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cit_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/cit_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "compacting_id_table_defines.svh"

module cit_engine
    import cit_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [ID_W-1:0]      cfg_wr_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire req_t                 in_req,
    input  wire logic [NAME_BITS-1:0] in_tag,
    input  wire logic [ID_W-1:0]      in_key,
    output ram_cmd_t                  ram_cmd,
    input  wire logic [ID_W-1:0]      rd_id,
    input  wire logic [NAME_BITS-1:0] rd_name,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output result_t                   res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ADD   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ID_W-1:0]      next_id_reg, next_id_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]     pend_idx_reg, pend_idx_next;
    req_t                 req_reg, req_next;
    logic [ID_W-1:0]      key_reg, key_next;
    logic [NAME_BITS-1:0] tag_reg, tag_next;
    status_t              status_reg, status_next;
    logic [ID_W-1:0]      rid_reg, rid_next;
    logic [NAME_BITS-1:0] rname_reg, rname_next;
    logic [CNT_W-1:0]     pend_dst;
    logic                 take;

    assign pend_dst = pend_idx_reg - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        ptr_next        = ptr_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        tag_next        = tag_reg;
        status_next     = status_reg;
        rid_next        = rid_reg;
        rname_next      = rname_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        take            = 1'b0;
        ram_cmd.we      = 1'b0;
        ram_cmd.waddr   = pend_dst[IDX_W-1:0];
        ram_cmd.raddr   = ptr_reg[IDX_W-1:0];
        ram_cmd.wid     = rd_id;
        ram_cmd.wname   = rd_name;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                take     = in_valid;
            end
            ST_ADD:
            begin
                if (count_reg >= CNT_W'(CAPACITY))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ram_cmd.we    = 1'b1;
                    ram_cmd.waddr = count_reg[IDX_W-1:0];
                    ram_cmd.wid   = next_id_reg;
                    ram_cmd.wname = tag_reg;
                    rid_next      = next_id_reg;
                    next_id_next  = next_id_reg + 1'b1;
                    count_next    = count_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                // Reads are issued one per cycle; the compare works on the
                // entry read in the previous cycle.
                if (ptr_reg < count_reg)
                begin
                    ptr_next        = ptr_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = ptr_reg;
                end
                if (pend_valid_reg && (rd_id == key_reg))
                begin
                    rid_next        = rd_id;
                    rname_next      = rd_name;
                    pend_valid_next = 1'b0;
                    if (req_reg == REQ_REMOVE)
                    begin
                        ptr_next   = pend_idx_reg + 1'b1;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (!pend_valid_reg && (ptr_reg >= count_reg))
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                // Entry i is read and written back to i - 1 in the next cycle.
                if (ptr_reg < count_reg)
                begin
                    ptr_next        = ptr_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = ptr_reg;
                end
                if (pend_valid_reg)
                begin
                    ram_cmd.we = 1'b1;
                end
                else if (ptr_reg >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    in_ready   = 1'b1;
                    take       = in_valid;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (take)
        begin
            req_next        = in_req;
            key_next        = in_key;
            tag_next        = in_tag;
            status_next     = STAT_OK;
            rid_next        = '0;
            rname_next      = '0;
            ptr_next        = '0;
            pend_valid_next = 1'b0;
            case (in_req)
                REQ_ADD:
                begin
                    state_next = ST_ADD;
                end
                REQ_FIND:
                begin
                    state_next = ST_SCAN;
                end
                REQ_REMOVE:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STAT_EMPTY;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
                default:
                begin
                    state_next = ST_DONE;
                end
            endcase
        end

        if (cfg_wr_en)
        begin
            next_id_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            next_id_reg    <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            req_reg        <= REQ_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            next_id_reg    <= next_id_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            req_reg        <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        key_reg      <= key_next;
        tag_reg      <= tag_next;
        status_reg   <= status_next;
        rid_reg      <= rid_next;
        rname_reg    <= rname_next;
    end

    assign res.status = status_reg;
    assign res.rid    = rid_reg;
    assign res.rname  = rname_reg;
    assign res.count  = count_out(count_reg);

    `CIT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `CIT_ASSERT_SAME(a_write_state, clk, rst_n, ram_cmd.we, (state_reg == ST_ADD) || (state_reg == ST_SHIFT))
    `CIT_ASSERT_SAME(a_shift_no_overlap, clk, rst_n, ram_cmd.we && (state_reg == ST_SHIFT), ram_cmd.waddr != ram_cmd.raddr)
    `CIT_ASSERT_NEXT(a_idle_count_hold, clk, rst_n, state_reg == ST_IDLE, $stable(count_reg))

endmodule

`default_nettype wire

// ===== rtl/compacting_id_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                        Contents
// s_*       in         tvalid, tready, tdata, tuser   one request per transfer
// m_*       out        tvalid, tready, tdata, tuser   one response per request
// cfg_*     in         wr_en, wr_data                 first_id, also reloads next id
//
// A find searches the id memory through its single read port one entry per
// cycle, from the first record up to the match or up to the record count when
// there is none. A remove finds the match the same way and then moves each
// later record down by one entry.
// Reset clears the record count and the id counter; the memories are not cleared.
// A stalled response waits in the output register while the next request runs.

module compacting_id_table
    import cit_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [ID_W-1:0]      cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // name_tag[63:0], key_id[95:64]
    input  wire logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // result_id[31:0], result_name[95:32],
                                                 // record_count[100:96]
    output logic [STATUS_W-1:0]       m_tuser    // status[1:0]
);

    ram_cmd_t             ram_cmd;
    logic [ID_W-1:0]      rd_id;
    logic [NAME_BITS-1:0] rd_name;
    logic                 res_valid;
    logic                 res_ready;
    result_t              res;
    logic                 m_valid_reg;
    result_t              out_reg;

    cit_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY)
    ) u_id_ram (
        .clk     (clk),
        .wr_en   (ram_cmd.we),
        .wr_addr (ram_cmd.waddr),
        .wr_data (ram_cmd.wid),
        .rd_addr (ram_cmd.raddr),
        .rd_data (rd_id)
    );

    cit_ram #(
        .WIDTH (NAME_BITS),
        .DEPTH (CAPACITY)
    ) u_name_ram (
        .clk     (clk),
        .wr_en   (ram_cmd.we),
        .wr_addr (ram_cmd.waddr),
        .wr_data (ram_cmd.wname),
        .rd_addr (ram_cmd.raddr),
        .rd_data (rd_name)
    );

    cit_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (req_t'(s_tuser)),
        .in_tag      (s_tdata[NAME_BITS-1:0]),
        .in_key      (s_tdata[TAG_W +: ID_W]),
        .ram_cmd     (ram_cmd),
        .rd_id       (rd_id),
        .rd_name     (rd_name),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg.count, TAG_W'(out_reg.rname), out_reg.rid};

endmodule

`default_nettype wire
